FILE: rtl/avlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package avlc_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int SIM_W       = 32;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int N_W         = IDX_W + 1;
    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TRI_W       = ADDR_W + 1;
    localparam int SZ_W        = N_W;
    localparam int PROD_W      = SIM_W + SZ_W + 1;
    localparam int T_W         = PROD_W + 4;
    localparam int D2_W        = SZ_W + 1;
    localparam int DCNT_W      = $clog2(T_W);
    localparam int NODE_W      = 2 * N_W;

    typedef struct packed {
        logic              st_we;
        logic              st_wsel;
        logic [ADDR_W-1:0] st_waddr;
        logic [ADDR_W-1:0] st_raddr;
        logic              scan_clr;
        logic              cmp_en;
        logic [IDX_W-1:0]  cmp_i;
        logic [IDX_W-1:0]  cmp_j;
        logic [IDX_W-1:0]  nd_raddr;
        logic              nd_we;
        logic [N_W-1:0]    nd_wid;
        logic              nd_clr;
        logic              lat_p;
        logic              lat_q;
        logic              emit;
        logic              last;
        logic              mul_a;
        logic              mul_b;
        logic              div_init;
        logic              div_step;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] q;
    } t_status;

    // row-major position of pair (min, max) in the upper triangle
    function automatic logic [ADDR_W-1:0] tri_index(input logic [N_W-1:0] n,
                                                    input logic [IDX_W-1:0] a,
                                                    input logic [IDX_W-1:0] b);
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [TRI_W-1:0] rowbase;
        logic [TRI_W-1:0] tri_sum;
        logic [TRI_W-1:0] res;
        lo      = (a < b) ? a : b;
        hi      = (a < b) ? b : a;
        rowbase = TRI_W'(lo) * TRI_W'(n);
        tri_sum = (TRI_W'(lo) * (TRI_W'(lo) + TRI_W'(1))) >> 1;
        res     = rowbase - tri_sum + TRI_W'(hi) - TRI_W'(lo) - TRI_W'(1);
        return res[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/avlc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module avlc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/avlc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module avlc_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [avlc_pkg::N_W-1:0]       i_cfg_data,
    input  wire logic                           start,
    input  wire logic                           i_last_entry,
    output logic                                busy,
    output avlc_pkg::t_cmd                      o_cmd,
    input  avlc_pkg::t_status                   i_status
);
    typedef enum logic [3:0] {
        S_LOAD, S_SCAN, S_SCAN_END, S_NODE_P, S_NODE_Q, S_EMIT, S_UPD_CHK,
        S_UPD_A, S_UPD_B, S_UPD_M, S_UPD_SUM, S_DIV, S_UPD_WR, S_MERGE
    } t_state;

    t_state                          r_state;
    logic [avlc_pkg::N_W-1:0]        r_item_count;
    logic [avlc_pkg::ADDR_W-1:0]     r_load_pos;
    logic [avlc_pkg::MAX_ITEMS-1:0]  r_active;
    logic [avlc_pkg::IDX_W-1:0]      r_mc;
    logic [avlc_pkg::IDX_W-1:0]      r_si;
    logic [avlc_pkg::IDX_W-1:0]      r_sj;
    logic [avlc_pkg::ADDR_W-1:0]     r_saddr;
    logic                            r_cv;
    logic [avlc_pkg::IDX_W-1:0]      r_ci;
    logic [avlc_pkg::IDX_W-1:0]      r_cj;
    logic [avlc_pkg::N_W-1:0]        r_ui;
    logic [avlc_pkg::DCNT_W-1:0]     r_dcnt;

    logic [avlc_pkg::N_W-1:0]        w_n;
    logic [avlc_pkg::IDX_W-1:0]      w_last_idx;
    logic [avlc_pkg::IDX_W-1:0]      w_last_mc;
    logic [avlc_pkg::ADDR_W-1:0]     w_entries;
    logic [avlc_pkg::IDX_W-1:0]      w_ui;
    logic [avlc_pkg::ADDR_W-1:0]     w_addr_p;
    logic [avlc_pkg::ADDR_W-1:0]     w_addr_q;
    logic                            w_accept;

    always_comb begin
        if (r_item_count < avlc_pkg::N_W'(2)) begin
            w_n = avlc_pkg::N_W'(2);
        end else if (r_item_count > avlc_pkg::N_W'(avlc_pkg::MAX_ITEMS)) begin
            w_n = avlc_pkg::N_W'(avlc_pkg::MAX_ITEMS);
        end else begin
            w_n = r_item_count;
        end
    end

    assign w_last_idx = avlc_pkg::IDX_W'(w_n - avlc_pkg::N_W'(1));
    assign w_last_mc  = avlc_pkg::IDX_W'(w_n - avlc_pkg::N_W'(2));
    assign w_entries  = avlc_pkg::ADDR_W'((avlc_pkg::TRI_W'(w_n)
                        * (avlc_pkg::TRI_W'(w_n) - avlc_pkg::TRI_W'(1))) >> 1);
    assign w_ui       = r_ui[avlc_pkg::IDX_W-1:0];
    assign w_addr_p   = avlc_pkg::tri_index(w_n, i_status.p, w_ui);
    assign w_addr_q   = avlc_pkg::tri_index(w_n, i_status.q, w_ui);
    assign busy       = (r_state != S_LOAD);
    assign w_accept   = start && !busy;

    always_comb begin
        o_cmd          = '0;
        o_cmd.cmp_en   = r_cv;
        o_cmd.cmp_i    = r_ci;
        o_cmd.cmp_j    = r_cj;
        o_cmd.st_raddr = r_saddr;
        o_cmd.st_waddr = r_load_pos;
        o_cmd.nd_wid   = w_n + avlc_pkg::N_W'(r_mc);
        o_cmd.last     = (r_mc == w_last_mc);
        case (r_state)
            S_LOAD: begin
                o_cmd.st_we = w_accept && (r_load_pos < w_entries);
            end
            S_SCAN: begin
                o_cmd.scan_clr = (r_saddr == '0);
            end
            S_NODE_P: begin
                o_cmd.nd_raddr = i_status.p;
            end
            S_NODE_Q: begin
                o_cmd.nd_raddr = i_status.q;
                o_cmd.lat_p    = 1'b1;
            end
            S_EMIT: begin
                o_cmd.lat_q = 1'b1;
                o_cmd.emit  = 1'b1;
            end
            S_UPD_A: begin
                o_cmd.st_raddr = w_addr_p;
            end
            S_UPD_B: begin
                o_cmd.st_raddr = w_addr_q;
                o_cmd.mul_a    = 1'b1;
            end
            S_UPD_M: begin
                o_cmd.mul_b = 1'b1;
            end
            S_UPD_SUM: begin
                o_cmd.div_init = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_UPD_WR: begin
                o_cmd.st_we    = 1'b1;
                o_cmd.st_wsel  = 1'b1;
                o_cmd.st_waddr = w_addr_p;
            end
            S_MERGE: begin
                o_cmd.nd_we  = 1'b1;
                o_cmd.nd_clr = (r_mc == w_last_mc);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_item_count <= avlc_pkg::N_W'(avlc_pkg::MAX_ITEMS);
            r_load_pos   <= '0;
            r_active     <= '1;
            r_mc         <= '0;
            r_si         <= '0;
            r_sj         <= '0;
            r_saddr      <= '0;
            r_cv         <= 1'b0;
            r_ci         <= '0;
            r_cj         <= '0;
            r_ui         <= '0;
            r_dcnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_item_count <= i_cfg_data;
            end
            r_cv <= (r_state == S_SCAN) && r_active[r_si] && r_active[r_sj];
            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (r_load_pos < w_entries) begin
                            r_load_pos <= r_load_pos + avlc_pkg::ADDR_W'(1);
                        end
                        if (i_last_entry) begin
                            r_state <= S_SCAN;
                            r_si    <= '0;
                            r_sj    <= avlc_pkg::IDX_W'(1);
                            r_saddr <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    r_ci    <= r_si;
                    r_cj    <= r_sj;
                    r_saddr <= r_saddr + avlc_pkg::ADDR_W'(1);
                    if (r_sj == w_last_idx) begin
                        if (r_si == w_last_idx - avlc_pkg::IDX_W'(1)) begin
                            r_state <= S_SCAN_END;
                        end
                        r_si <= r_si + avlc_pkg::IDX_W'(1);
                        r_sj <= r_si + avlc_pkg::IDX_W'(2);
                    end else begin
                        r_sj <= r_sj + avlc_pkg::IDX_W'(1);
                    end
                end
                S_SCAN_END: begin
                    r_state <= S_NODE_P;
                end
                S_NODE_P: begin
                    r_state <= S_NODE_Q;
                end
                S_NODE_Q: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_active[i_status.q] <= 1'b0;
                    r_ui                 <= '0;
                    r_state              <= S_UPD_CHK;
                end
                S_UPD_CHK: begin
                    if (r_ui == w_n) begin
                        r_state <= S_MERGE;
                    end else if (r_active[w_ui] && (w_ui != i_status.p)) begin
                        r_state <= S_UPD_A;
                    end else begin
                        r_ui <= r_ui + avlc_pkg::N_W'(1);
                    end
                end
                S_UPD_A: begin
                    r_state <= S_UPD_B;
                end
                S_UPD_B: begin
                    r_state <= S_UPD_M;
                end
                S_UPD_M: begin
                    r_state <= S_UPD_SUM;
                end
                S_UPD_SUM: begin
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + avlc_pkg::DCNT_W'(1);
                    if (r_dcnt == avlc_pkg::DCNT_W'(avlc_pkg::T_W - 1)) begin
                        r_state <= S_UPD_WR;
                    end
                end
                S_UPD_WR: begin
                    r_ui    <= r_ui + avlc_pkg::N_W'(1);
                    r_state <= S_UPD_CHK;
                end
                S_MERGE: begin
                    if (r_mc == w_last_mc) begin
                        // end of run: back to a fresh load
                        r_active   <= '1;
                        r_load_pos <= '0;
                        r_mc       <= '0;
                        r_state    <= S_LOAD;
                    end else begin
                        r_mc    <= r_mc + avlc_pkg::IDX_W'(1);
                        r_si    <= '0;
                        r_sj    <= avlc_pkg::IDX_W'(1);
                        r_saddr <= '0;
                        r_state <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/avlc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module avlc_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic signed [avlc_pkg::SIM_W-1:0] i_similarity,
    input  avlc_pkg::t_cmd                         i_cmd,
    output avlc_pkg::t_status                      o_status,
    output logic                                   o_strobe,
    output logic [avlc_pkg::N_W-1:0]               o_left_node,
    output logic [avlc_pkg::N_W-1:0]               o_right_node,
    output logic signed [avlc_pkg::SIM_W-1:0]      o_merge_similarity,
    output logic                                   o_last_merge
);
    logic signed [avlc_pkg::SIM_W-1:0]   w_st_rdata;
    logic [avlc_pkg::SIM_W-1:0]          w_st_rraw;
    logic [avlc_pkg::SIM_W-1:0]          w_st_wdata;
    logic signed [avlc_pkg::SIM_W-1:0]   w_avg;

    logic [avlc_pkg::NODE_W-1:0]         w_nd_rdata;
    logic [avlc_pkg::NODE_W-1:0]         w_nd_wdata;
    logic [avlc_pkg::MAX_ITEMS-1:0]      r_nvalid;
    logic                                r_nv_q;
    logic [avlc_pkg::IDX_W-1:0]          r_nraddr;
    logic [avlc_pkg::N_W-1:0]            w_nd_id;
    logic [avlc_pkg::SZ_W-1:0]           w_nd_sz;

    logic                                r_found;
    logic signed [avlc_pkg::SIM_W-1:0]   r_best;
    logic [avlc_pkg::IDX_W-1:0]          r_p;
    logic [avlc_pkg::IDX_W-1:0]          r_q;
    logic [avlc_pkg::N_W-1:0]            r_id_p;
    logic [avlc_pkg::SZ_W-1:0]           r_sp;
    logic [avlc_pkg::SZ_W-1:0]           r_sq;
    logic [avlc_pkg::SZ_W-1:0]           w_den;

    logic signed [avlc_pkg::PROD_W-1:0]  r_pa;
    logic signed [avlc_pkg::PROD_W-1:0]  r_pb;
    logic signed [avlc_pkg::T_W-1:0]     w_t;
    logic [avlc_pkg::T_W-1:0]            w_mag;
    logic [avlc_pkg::D2_W-1:0]           w_d2;
    logic [avlc_pkg::D2_W-1:0]           r_d2;
    logic [avlc_pkg::D2_W-1:0]           r_rem;
    logic [avlc_pkg::T_W-1:0]            r_quo;
    logic                                r_neg;
    logic [avlc_pkg::D2_W:0]             w_trial;
    logic [avlc_pkg::T_W-1:0]            w_qsigned;

    assign w_st_rdata = $signed(w_st_rraw);
    assign w_st_wdata = i_cmd.st_wsel ? w_avg : i_similarity;

    avlc_ram #(
        .WIDTH(avlc_pkg::SIM_W),
        .DEPTH(avlc_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.st_we),
        .i_waddr(i_cmd.st_waddr),
        .i_wdata(w_st_wdata),
        .i_raddr(i_cmd.st_raddr),
        .o_rdata(w_st_rraw)
    );

    // node id and cluster size per slot; an unwritten slot is a single leaf
    assign w_den      = r_sp + r_sq;
    assign w_nd_wdata = {i_cmd.nd_wid, w_den};

    avlc_ram #(
        .WIDTH(avlc_pkg::NODE_W),
        .DEPTH(avlc_pkg::MAX_ITEMS)
    ) u_nodes (
        .i_clk  (i_clk),
        .i_we   (i_cmd.nd_we),
        .i_waddr(r_p),
        .i_wdata(w_nd_wdata),
        .i_raddr(i_cmd.nd_raddr),
        .o_rdata(w_nd_rdata)
    );

    assign w_nd_id = r_nv_q ? w_nd_rdata[avlc_pkg::NODE_W-1:avlc_pkg::SZ_W]
                            : avlc_pkg::N_W'(r_nraddr);
    assign w_nd_sz = r_nv_q ? w_nd_rdata[avlc_pkg::SZ_W-1:0] : avlc_pkg::SZ_W'(1);

    assign o_status.p = r_p;
    assign o_status.q = r_q;

    // floor((2*num + den) / (2*den)) via magnitude division
    assign w_d2  = {1'b0, w_den} << 1;
    assign w_t   = ((avlc_pkg::T_W'(r_pa) + avlc_pkg::T_W'(r_pb)) <<< 1)
                   + $signed(avlc_pkg::T_W'(w_den));
    assign w_mag = w_t[avlc_pkg::T_W-1]
                   ? (avlc_pkg::T_W'(-w_t) + avlc_pkg::T_W'(w_d2) - avlc_pkg::T_W'(1))
                   : avlc_pkg::T_W'(w_t);
    assign w_trial   = {r_rem, r_quo[avlc_pkg::T_W-1]};
    assign w_qsigned = r_neg ? (-r_quo) : r_quo;
    assign w_avg     = $signed(w_qsigned[avlc_pkg::SIM_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvalid <= '0;
            r_found  <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit;
            if (i_cmd.nd_clr) begin
                r_nvalid <= '0;
            end else if (i_cmd.nd_we) begin
                r_nvalid[r_p] <= 1'b1;
            end
            if (i_cmd.scan_clr) begin
                r_found <= 1'b0;
            end else if (i_cmd.cmp_en && (!r_found || (w_st_rdata > r_best))) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nv_q   <= r_nvalid[i_cmd.nd_raddr];
        r_nraddr <= i_cmd.nd_raddr;
        if (i_cmd.cmp_en && !i_cmd.scan_clr && (!r_found || (w_st_rdata > r_best))) begin
            r_best <= w_st_rdata;
            r_p    <= i_cmd.cmp_i;
            r_q    <= i_cmd.cmp_j;
        end
        if (i_cmd.lat_p) begin
            r_id_p <= w_nd_id;
            r_sp   <= w_nd_sz;
        end
        if (i_cmd.lat_q) begin
            r_sq <= w_nd_sz;
        end
        if (i_cmd.emit) begin
            o_left_node        <= r_id_p;
            o_right_node       <= w_nd_id;
            o_merge_similarity <= r_best;
            o_last_merge       <= i_cmd.last;
        end
        if (i_cmd.mul_a) begin
            r_pa <= $signed({1'b0, r_sp}) * w_st_rdata;
        end
        if (i_cmd.mul_b) begin
            r_pb <= $signed({1'b0, r_sq}) * w_st_rdata;
        end
        if (i_cmd.div_init) begin
            r_neg <= w_t[avlc_pkg::T_W-1];
            r_quo <= w_mag;
            r_rem <= '0;
            r_d2  <= w_d2;
        end else if (i_cmd.div_step) begin
            if (w_trial >= {1'b0, r_d2}) begin
                r_rem <= avlc_pkg::D2_W'(w_trial - {1'b0, r_d2});
                r_quo <= {r_quo[avlc_pkg::T_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[avlc_pkg::D2_W-1:0];
                r_quo <= {r_quo[avlc_pkg::T_W-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/average_linkage_agglomerative_clustering_top.sv
// Matrix load: one entry per cycle while busy is low; busy rises after the final entry.
// Each merge: one pass over all pairs of the triangle (one store read per pair), then per
// surviving cluster one update through the bit-serial rounding divider.
// One result per merge, strobed for one cycle; the receiver cannot stall. busy drops after
// the last merge. Synchronous active-low reset; item_count resets to 64, the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module average_linkage_agglomerative_clustering_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [avlc_pkg::N_W-1:0]          i_cfg_data,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [avlc_pkg::SIM_W-1:0] i_similarity,
    input  wire logic                              i_last_entry,
    output logic                                   o_strobe,
    output logic [avlc_pkg::N_W-1:0]               o_left_node,
    output logic [avlc_pkg::N_W-1:0]               o_right_node,
    output logic signed [avlc_pkg::SIM_W-1:0]      o_merge_similarity,
    output logic                                   o_last_merge
);
    avlc_pkg::t_cmd    w_cmd;
    avlc_pkg::t_status w_status;

    avlc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .i_last_entry(i_last_entry),
        .busy        (busy),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    avlc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_similarity      (i_similarity),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_strobe          (o_strobe),
        .o_left_node       (o_left_node),
        .o_right_node      (o_right_node),
        .o_merge_similarity(o_merge_similarity),
        .o_last_merge      (o_last_merge)
    );
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    localparam int WDOG_LIMIT = 40000;
    localparam int RAND_ITEMS = 110;

    typedef struct {
        logic [avlc_pkg::N_W-1:0]          left_id;
        logic [avlc_pkg::N_W-1:0]          right_id;
        logic signed [avlc_pkg::SIM_W-1:0] sim;
        logic                              last;
    } t_merge;

    class merge_scoreboard;
        t_merge                            merges_q[$];
        logic signed [avlc_pkg::SIM_W-1:0] sim_mem[avlc_pkg::STORE_DEPTH];
        logic [avlc_pkg::MAX_ITEMS-1:0]    alive;
        int unsigned                       csize[avlc_pkg::MAX_ITEMS];
        int unsigned                       nid[avlc_pkg::MAX_ITEMS];
        int unsigned                       load_pos;
        int unsigned                       count_reg;
        int                                errors;

        function new();
            count_reg = avlc_pkg::MAX_ITEMS;
            errors    = 0;
            restart();
        endfunction

        function void restart();
            alive = '1;
            for (int k = 0; k < avlc_pkg::MAX_ITEMS; k++) begin
                csize[k] = 1;
                nid[k]   = k;
            end
            load_pos = 0;
        endfunction

        function int unsigned items();
            if (count_reg < 2) return 2;
            if (count_reg > avlc_pkg::MAX_ITEMS) return avlc_pkg::MAX_ITEMS;
            return count_reg;
        endfunction

        function int unsigned pair_addr(int unsigned n, int unsigned a, int unsigned b);
            int unsigned lo;
            int unsigned hi;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            return (lo * n - (lo * (lo + 1)) / 2 + (hi - lo - 1)) % avlc_pkg::STORE_DEPTH;
        endfunction

        // nearest, ties toward +inf
        function longint avg_round(longint num, longint den);
            longint t;
            longint d2;
            t  = 2 * num + den;
            d2 = 2 * den;
            if (t >= 0) return t / d2;
            return -((-t + d2 - 1) / d2);
        endfunction

        function void note_entry(logic signed [avlc_pkg::SIM_W-1:0] v, logic last);
            int unsigned n;
            int unsigned p;
            int unsigned q;
            int unsigned sp;
            int unsigned sq;
            longint      best;
            longint      a;
            longint      b;
            bit          found;
            t_merge      m;
            n = items();
            if (load_pos < n * (n - 1) / 2) begin
                sim_mem[load_pos] = v;
                load_pos++;
            end
            if (!last) return;
            for (int unsigned k = 0; k + 1 < n; k++) begin
                found = 0;
                best  = 0;
                p     = 0;
                q     = 0;
                for (int unsigned i = 0; i < n; i++) begin
                    if (!alive[i]) continue;
                    for (int unsigned j = i + 1; j < n; j++) begin
                        if (!alive[j]) continue;
                        a = sim_mem[pair_addr(n, i, j)];
                        if (!found || a > best) begin
                            found = 1;
                            best  = a;
                            p     = i;
                            q     = j;
                        end
                    end
                end
                if (!found) break;
                m.left_id  = nid[p];
                m.right_id = nid[q];
                m.sim      = best;
                m.last     = (k + 2 == n);
                merges_q.push_back(m);
                nid[p]   = (n + k) & 7'h7f;
                alive[q] = 1'b0;
                sp = csize[p];
                sq = csize[q];
                for (int unsigned i = 0; i < n; i++) begin
                    if (!alive[i] || i == p) continue;
                    a = sim_mem[pair_addr(n, p, i)];
                    b = sim_mem[pair_addr(n, q, i)];
                    sim_mem[pair_addr(n, p, i)] = avg_round(sp * a + sq * b, sp + sq);
                end
                csize[p] = (sp + sq) & 7'h7f;
            end
            restart();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_merge(logic [avlc_pkg::N_W-1:0] l, logic [avlc_pkg::N_W-1:0] r,
                         logic signed [avlc_pkg::SIM_W-1:0] s, logic last);
            t_merge e;
            if (merges_q.size() == 0) begin
                report_mismatch($sformatf("unexpected merge %0d/%0d sim %0d", l, r, s));
                return;
            end
            e = merges_q.pop_front();
            if (l !== e.left_id)
                report_mismatch($sformatf("left_node %0d, want %0d", l, e.left_id));
            if (r !== e.right_id)
                report_mismatch($sformatf("right_node %0d, want %0d", r, e.right_id));
            if (s !== e.sim)
                report_mismatch($sformatf("merge_similarity %0d, want %0d", s, e.sim));
            if (last !== e.last)
                report_mismatch($sformatf("last_merge %0b, want %0b", last, e.last));
        endtask
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [avlc_pkg::N_W-1:0]          i_cfg_data = '0;
    logic                              start = 1'b0;
    logic                              busy;
    logic signed [avlc_pkg::SIM_W-1:0] i_similarity = '0;
    logic                              i_last_entry = 1'b0;
    logic                              o_strobe;
    logic [avlc_pkg::N_W-1:0]          o_left_node;
    logic [avlc_pkg::N_W-1:0]          o_right_node;
    logic signed [avlc_pkg::SIM_W-1:0] o_merge_similarity;
    logic                              o_last_merge;

    merge_scoreboard sb = new();
    int              idle_off = 0;
    int              wdog = 0;

    average_linkage_agglomerative_clustering_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .start              (start),
        .busy               (busy),
        .i_similarity       (i_similarity),
        .i_last_entry       (i_last_entry),
        .o_strobe           (o_strobe),
        .o_left_node        (o_left_node),
        .o_right_node       (o_right_node),
        .o_merge_similarity (o_merge_similarity),
        .o_last_merge       (o_last_merge)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_merge(o_left_node, o_right_node, o_merge_similarity, o_last_merge);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy)) begin
            wdog <= 0;
        end else if (wdog >= WDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("== FAIL ==");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    function automatic logic signed [avlc_pkg::SIM_W-1:0] pick_sim();
        case ($urandom_range(0, 9))
            0, 1, 2: return 32'(($urandom_range(0, 4) - 2) * 65536);
            3:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // holds start until the transaction goes through
    task automatic send_entry(logic signed [avlc_pkg::SIM_W-1:0] v, logic last);
        int gap;
        @(negedge i_clk);
        start        <= 1'b1;
        i_similarity <= v;
        i_last_entry <= last;
        do @(posedge i_clk); while (busy);
        sb.note_entry(v, last);
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        do @(posedge i_clk); while (sb.merges_q.size() != 0 || busy);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_count(int unsigned v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= avlc_pkg::N_W'(v);
        sb.count_reg = v & 7'h7f;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // loads a matrix; early cuts the load short, extra adds ignored entries
    task automatic run_matrix(int unsigned early, int unsigned extra, inout int sent);
        int unsigned total;
        total = sb.items() * (sb.items() - 1) / 2;
        if (early != 0) total = early;
        total += extra;
        for (int unsigned k = 1; k <= total; k++) begin
            send_entry(pick_sim(), k == total);
            sent++;
        end
        wait_drained();
    endtask

    initial begin
        int sent;
        int n;
        int mode;
        sent = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // largest size used below goes first, so short loads only read written entries
        write_count(12);
        run_matrix(0, 0, sent);
        write_count(2);
        send_entry(32'h8000_0000, 1'b1);
        send_entry(32'h7fff_ffff, 1'b1);
        wait_drained();
        write_count(0);
        send_entry(32'h0000_0000, 1'b1);
        wait_drained();
        write_count(1);
        send_entry(32'hffff_ffff, 1'b1);
        wait_drained();
        write_count(3);
        // all ties: first pair in scan order wins
        for (int k = 0; k < 3; k++) send_entry(32'sh0001_0000, k == 2);
        wait_drained();
        write_count(3);
        run_matrix(0, 3, sent);
        write_count(4);
        run_matrix(2, 0, sent);

        while (sent < RAND_ITEMS) begin
            mode = $urandom_range(0, 9);
            n    = $urandom_range(2, 7);
            if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 1);
            if ($urandom_range(0, 9) == 0) n = $urandom_range(8, 12);
            write_count(n);
            if (sent > RAND_ITEMS - 30) idle_off = 1;
            if (mode == 0)
                run_matrix($urandom_range(1, sb.items() * (sb.items() - 1) / 2), 0, sent);
            else if (mode == 1)
                run_matrix(0, $urandom_range(1, 3), sent);
            else
                run_matrix(0, 0, sent);
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.merges_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            if (sb.merges_q.size() != 0)
                sb.report_mismatch($sformatf("%0d merges never came", sb.merges_q.size()));
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/avlc_pkg.sv
rtl/avlc_ram.sv
rtl/avlc_ctrl.sv
rtl/avlc_dp.sv
rtl/average_linkage_agglomerative_clustering_top.sv
dv/tb_top.sv
